@@ rtl/dss_pkg.sv @@
// dss_pkg: shared constants, register codes and types for the diffusion stencil step unit.
// No dependencies; compiled first.
package dss_pkg;

   localparam int VALUE_BITS_DEF = 16;
   localparam int MAX_COLS_DEF   = 1024;
   localparam int MAX_ROWS       = 1024;
   localparam int ROW_BITS       = 10;
   localparam int COORD_BITS     = 10;
   localparam int ALPHA_BITS     = 15;
   localparam int GRID_BITS      = 11;
   localparam int FRAC_BITS      = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int RESULT_LANES   = 3;
   localparam int OUT_FIFO_DEPTH = 16;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_ALPHA = 2'd0;
   localparam csr_index_type CSR_COLS  = 2'd1;
   localparam csr_index_type CSR_ROWS  = 2'd2;

   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET     = 15'd13107;
   localparam logic [GRID_BITS-1:0]  GRID_COLS_RESET = 11'd256;
   localparam logic [GRID_BITS-1:0]  GRID_ROWS_RESET = 11'd256;

endpackage

@@ rtl/dss_ifs.sv @@
// Channel interfaces of the diffusion stencil step unit: grid words in, results out, CSR writes.
// Depends on dss_pkg.
interface dss_req_if import dss_pkg::*; #(parameter int VALUE_BITS = VALUE_BITS_DEF);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] cell_value;
   logic                  frame_start;

   modport source (output valid, cell_value, frame_start, input ready);
   modport sink   (input valid, cell_value, frame_start, output ready);
endinterface

interface dss_rsp_if import dss_pkg::*; #(parameter int VALUE_BITS = VALUE_BITS_DEF);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] new_value;
   logic [COORD_BITS-1:0] out_row;
   logic [COORD_BITS-1:0] out_col;
   logic                  run_last;

   modport source (output valid, new_value, out_row, out_col, run_last, input ready);
   modport sink   (input valid, new_value, out_row, out_col, run_last, output ready);
endinterface

interface dss_csr_if import dss_pkg::*;;
   logic                     valid;
   logic                     ready;
   csr_index_type            reg_index;
   logic [CSR_DATA_BITS-1:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

@@ rtl/diffusion_stencil_step_unit.sv @@
// Diffusion stencil step unit: one explicit FTCS step of 2D diffusion over a raster-order grid
// stream, reflective boundary, rounded and saturated. Takes one grid word per clock whenever
// the result queue has room for three more results. Each word yields zero to three results
// (the cell above it, and on the last row the cell before it and the grid's last cell), which
// leave one per clock, so the sustained rate is one word per cycle for interior rows and is set
// by the result port on the last row. From the accepted word to its first result on the port
// the path runs through line buffer read, stencil multiply and rounding into the queue.
// Line buffers are not cleared after reset; the block is ready at once.
// Depends on dss_pkg, dss_ifs, dss_ram, dss_cell, dss_stencil.
module diffusion_stencil_step_unit import dss_pkg::*; #(
   parameter int MAX_COLS   = MAX_COLS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   dss_req_if.sink    req_ch,
   dss_rsp_if.source  rsp_ch,
   dss_csr_if.sink    csr_ch
);

   localparam int CW   = $clog2(MAX_COLS);
   localparam int LW   = ((CW > GRID_BITS) ? CW : GRID_BITS) + 1;
   localparam int PTRW = $clog2(OUT_FIFO_DEPTH);
   localparam int CRW  = $clog2(OUT_FIFO_DEPTH + 1);

   // configuration
   logic [ALPHA_BITS-1:0] alpha_ff;
   logic [GRID_BITS-1:0]  grid_cols_ff;
   logic [GRID_BITS-1:0]  grid_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_RESET;
         grid_cols_ff <= GRID_COLS_RESET;
         grid_rows_ff <= GRID_ROWS_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.reg_index)
            CSR_ALPHA: alpha_ff     <= csr_ch.wr_data[ALPHA_BITS-1:0];
            CSR_COLS:  grid_cols_ff <= csr_ch.wr_data[GRID_BITS-1:0];
            CSR_ROWS:  grid_rows_ff <= csr_ch.wr_data[GRID_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   // accept stage: position and line buffer read
   logic [LW-1:0]        cols_ext;
   logic [LW-1:0]        cols_eff;
   logic [GRID_BITS-1:0] rows_eff;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [ROW_BITS-1:0]  a_r;
   logic [CW-1:0]        a_c;
   logic [CW-1:0]        a_c_next;
   logic                 a_last_col;
   logic                 a_last_row;
   logic                 req_ready;
   logic                 acc;
   logic [CRW-1:0]       credit_ff, credit_in;

   always_comb begin
      cols_ext = LW'(grid_cols_ff);
      if (cols_ext == '0) begin
         cols_eff = LW'(1);
      end else if (cols_ext > LW'(MAX_COLS)) begin
         cols_eff = LW'(MAX_COLS);
      end else begin
         cols_eff = cols_ext;
      end
      if (grid_rows_ff == '0) begin
         rows_eff = GRID_BITS'(1);
      end else if (grid_rows_ff > GRID_BITS'(MAX_ROWS)) begin
         rows_eff = GRID_BITS'(MAX_ROWS);
      end else begin
         rows_eff = grid_rows_ff;
      end
      a_r        = req_ch.frame_start ? '0 : row_ff;
      a_c        = req_ch.frame_start ? '0 : col_ff;
      a_c_next   = a_c + CW'(1);
      a_last_col = LW'(a_c) >= (cols_eff - LW'(1));
      a_last_row = GRID_BITS'(a_r) >= (rows_eff - GRID_BITS'(1));
      req_ready  = credit_ff >= CRW'(RESULT_LANES);
      acc        = req_ch.valid & req_ready;
      row_in     = row_ff;
      col_in     = col_ff;
      if (acc) begin
         if (a_last_col) begin
            col_in = '0;
            row_in = a_last_row ? '0 : a_r + ROW_BITS'(1);
         end else begin
            col_in = a_c_next;
            row_in = a_r;
         end
      end
   end

   assign req_ch.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // stage B: neighbor assembly, buffer write, window shift
   logic                  b_valid_ff;
   logic                  b_fwd_ff;
   logic [VALUE_BITS-1:0] b_x_ff;
   logic [ROW_BITS-1:0]   b_r_ff;
   logic [CW-1:0]         b_c_ff;
   logic                  b_last_col_ff;
   logic                  b_last_row_ff;
   logic [CW-1:0]         prev_c_ff;
   logic [VALUE_BITS-1:0] prev_x_ff;
   logic [VALUE_BITS-1:0] prev_mid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_fwd_ff   <= 1'b0;
      end else begin
         b_valid_ff <= acc;
         b_fwd_ff   <= b_valid_ff;
      end
   end

   logic [VALUE_BITS-1:0] mid_rd_a, mid_rd_b, up_rd_a;
   logic [VALUE_BITS-1:0] b_mid_c, b_mid_c1, b_up_c;
   logic [VALUE_BITS-1:0] win0, win1, win2;

   always_ff @(posedge clock) begin
      if (acc) begin
         b_x_ff        <= req_ch.cell_value;
         b_r_ff        <= a_r;
         b_c_ff        <= a_c;
         b_last_col_ff <= a_last_col;
         b_last_row_ff <= a_last_row;
      end
      if (b_valid_ff) begin
         prev_c_ff   <= b_c_ff;
         prev_x_ff   <= b_x_ff;
         prev_mid_ff <= b_mid_c;
      end
   end

   dss_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_COLS)) u_middle_line (
      .clock     (clock),
      .wr_en     (b_valid_ff),
      .wr_addr   (b_c_ff),
      .wr_data   (b_x_ff),
      .rd_a_addr (a_c),
      .rd_a_data (mid_rd_a),
      .rd_b_addr (a_c_next),
      .rd_b_data (mid_rd_b)
   );

   dss_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_COLS)) u_upper_line (
      .clock     (clock),
      .wr_en     (b_valid_ff),
      .wr_addr   (b_c_ff),
      .wr_data   (b_mid_c),
      .rd_a_addr (a_c),
      .rd_a_data (up_rd_a),
      .rd_b_addr (a_c),
      .rd_b_data ()
   );

   // previous word writes on the edge this word reads: forward it
   always_comb begin
      b_mid_c  = (b_fwd_ff && (b_c_ff == prev_c_ff)) ? prev_x_ff : mid_rd_a;
      b_up_c   = (b_fwd_ff && (b_c_ff == prev_c_ff)) ? prev_mid_ff : up_rd_a;
      b_mid_c1 = (b_fwd_ff && ((b_c_ff + CW'(1)) == prev_c_ff)) ? prev_x_ff : mid_rd_b;
   end

   dss_cell #(.WIDTH(VALUE_BITS)) u_win0 (
      .clock (clock), .reset (reset), .shift_en (b_valid_ff), .d (b_mid_c), .q (win0)
   );
   dss_cell #(.WIDTH(VALUE_BITS)) u_win1 (
      .clock (clock), .reset (reset), .shift_en (b_valid_ff), .d (b_x_ff), .q (win1)
   );
   dss_cell #(.WIDTH(VALUE_BITS)) u_win2 (
      .clock (clock), .reset (reset), .shift_en (b_valid_ff), .d (win1), .q (win2)
   );

   logic                  lane_valid [RESULT_LANES];
   logic [VALUE_BITS-1:0] lane_ctr   [RESULT_LANES];
   logic [VALUE_BITS-1:0] lane_up    [RESULT_LANES];
   logic [VALUE_BITS-1:0] lane_dn    [RESULT_LANES];
   logic [VALUE_BITS-1:0] lane_lf    [RESULT_LANES];
   logic [VALUE_BITS-1:0] lane_rt    [RESULT_LANES];
   logic [ROW_BITS-1:0]   lane_row   [RESULT_LANES];
   logic [CW-1:0]         lane_col   [RESULT_LANES];

   always_comb begin
      // cell above the incoming word
      lane_valid[0] = b_r_ff != '0;
      lane_ctr[0]   = b_mid_c;
      lane_up[0]    = (b_r_ff == ROW_BITS'(1)) ? b_mid_c : b_up_c;
      lane_dn[0]    = b_x_ff;
      lane_lf[0]    = (b_c_ff != '0) ? win0 : b_mid_c;
      lane_rt[0]    = b_last_col_ff ? b_mid_c : b_mid_c1;
      lane_row[0]   = b_r_ff - ROW_BITS'(1);
      lane_col[0]   = b_c_ff;
      // last row: cell left of the incoming word
      lane_valid[1] = b_last_row_ff && (b_c_ff != '0);
      lane_ctr[1]   = win1;
      lane_up[1]    = (b_r_ff != '0) ? win0 : win1;
      lane_dn[1]    = win1;
      lane_lf[1]    = (b_c_ff > CW'(1)) ? win2 : win1;
      lane_rt[1]    = b_x_ff;
      lane_row[1]   = b_r_ff;
      lane_col[1]   = b_c_ff - CW'(1);
      // last cell of the grid
      lane_valid[2] = b_last_row_ff && b_last_col_ff;
      lane_ctr[2]   = b_x_ff;
      lane_up[2]    = (b_r_ff != '0) ? b_mid_c : b_x_ff;
      lane_dn[2]    = b_x_ff;
      lane_lf[2]    = (b_c_ff != '0) ? win1 : b_x_ff;
      lane_rt[2]    = b_x_ff;
      lane_row[2]   = b_r_ff;
      lane_col[2]   = b_c_ff;
   end

   // stage C: rounding, then into the result queue
   logic                  c_valid_ff;
   logic                  c_lane_valid_ff [RESULT_LANES];
   logic [ROW_BITS-1:0]   c_row_ff        [RESULT_LANES];
   logic [CW-1:0]         c_col_ff        [RESULT_LANES];
   logic [VALUE_BITS-1:0] c_result        [RESULT_LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         for (int k = 0; k < RESULT_LANES; k++) begin
            c_lane_valid_ff[k] <= 1'b0;
         end
      end else begin
         c_valid_ff <= b_valid_ff;
         for (int k = 0; k < RESULT_LANES; k++) begin
            c_lane_valid_ff[k] <= b_valid_ff & lane_valid[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < RESULT_LANES; k++) begin
         c_row_ff[k] <= lane_row[k];
         c_col_ff[k] <= lane_col[k];
      end
   end

   for (genvar g = 0; g < RESULT_LANES; g++) begin : g_lane
      dss_stencil #(.VALUE_BITS(VALUE_BITS)) u_stencil (
         .clock    (clock),
         .alpha    (alpha_ff),
         .center   (lane_ctr[g]),
         .nb_up    (lane_up[g]),
         .nb_down  (lane_dn[g]),
         .nb_left  (lane_lf[g]),
         .nb_right (lane_rt[g]),
         .result   (c_result[g])
      );
   end

   // result queue
   logic [VALUE_BITS-1:0] fifo_value [OUT_FIFO_DEPTH];
   logic [COORD_BITS-1:0] fifo_row   [OUT_FIFO_DEPTH];
   logic [COORD_BITS-1:0] fifo_col   [OUT_FIFO_DEPTH];
   logic                  fifo_last  [OUT_FIFO_DEPTH];
   logic [PTRW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CRW-1:0]        fifo_count_ff, fifo_count_in;
   logic [PTRW-1:0]       slot       [RESULT_LANES];
   logic                  lane_last  [RESULT_LANES];
   logic [1:0]            npush;
   logic [CRW:0]          credit_sum;
   logic                  rsp_valid;
   logic                  pop;

   always_comb begin
      npush = {1'b0, c_lane_valid_ff[0]} + {1'b0, c_lane_valid_ff[1]}
            + {1'b0, c_lane_valid_ff[2]};
      slot[0] = wr_ptr_ff;
      slot[1] = wr_ptr_ff + PTRW'(c_lane_valid_ff[0]);
      slot[2] = wr_ptr_ff + PTRW'(c_lane_valid_ff[0]) + PTRW'(c_lane_valid_ff[1]);
      lane_last[0] = c_lane_valid_ff[0] & ~c_lane_valid_ff[1] & ~c_lane_valid_ff[2];
      lane_last[1] = c_lane_valid_ff[1] & ~c_lane_valid_ff[2];
      lane_last[2] = c_lane_valid_ff[2];
      rsp_valid = fifo_count_ff != '0;
      pop       = rsp_valid & rsp_ch.ready;
      wr_ptr_in = wr_ptr_ff + PTRW'(npush);
      rd_ptr_in = rd_ptr_ff + PTRW'(pop);
      fifo_count_in = fifo_count_ff + CRW'(npush) - CRW'(pop);
      // three slots reserved per accepted word, unused ones given back at stage C
      credit_sum = (CRW+1)'(credit_ff) + (CRW+1)'(pop)
                 - (acc ? (CRW+1)'(RESULT_LANES) : '0)
                 + (c_valid_ff ? (CRW+1)'(RESULT_LANES) - (CRW+1)'(npush) : '0);
      credit_in  = credit_sum[CRW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
         credit_ff     <= CRW'(OUT_FIFO_DEPTH);
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fifo_count_ff <= fifo_count_in;
         credit_ff     <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < RESULT_LANES; k++) begin
         if (c_lane_valid_ff[k]) begin
            fifo_value[slot[k]] <= c_result[k];
            fifo_row[slot[k]]   <= COORD_BITS'(c_row_ff[k]);
            fifo_col[slot[k]]   <= COORD_BITS'(c_col_ff[k]);
            fifo_last[slot[k]]  <= lane_last[k];
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid;
   assign rsp_ch.new_value = fifo_value[rd_ptr_ff];
   assign rsp_ch.out_row   = fifo_row[rd_ptr_ff];
   assign rsp_ch.out_col   = fifo_col[rd_ptr_ff];
   assign rsp_ch.run_last  = fifo_last[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      ((CRW+3)'(fifo_count_ff) + (CRW+3)'(credit_ff)
       + (b_valid_ff ? (CRW+3)'(RESULT_LANES) : '0)
       + (c_valid_ff ? (CRW+3)'(RESULT_LANES) : '0)) == (CRW+3)'(OUT_FIFO_DEPTH))
      else $error("result queue slots lost or double counted");

   a_word_flow: assert property (@(posedge clock) disable iff (reset)
      acc |=> b_valid_ff ##1 c_valid_ff)
      else $error("accepted word did not pass through the pipeline");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> ((CRW+1)'(fifo_count_ff) + (CRW+1)'(npush)
                      <= (CRW+1)'(OUT_FIFO_DEPTH)))
      else $error("result queue overflow");
`endif

endmodule

@@ rtl/dss_ram.sv @@
// dss_ram: generic RAM, one write port and two registered read ports.
// No dependencies.
module dss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

@@ rtl/dss_cell.sv @@
// dss_cell: one cell of the neighbor window chain; loads its input word on each shift.
// No dependencies.
module dss_cell #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] q_ff;
   logic [WIDTH-1:0] q_in;

   always_comb begin
      q_in = shift_en ? d : q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

@@ rtl/dss_stencil.sv @@
// dss_stencil: five-point update c + alpha*lap, product registered, then round and saturate.
// Depends on dss_pkg.
module dss_stencil import dss_pkg::*; #(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic [ALPHA_BITS-1:0] alpha,
   input  logic [VALUE_BITS-1:0] center,
   input  logic [VALUE_BITS-1:0] nb_up,
   input  logic [VALUE_BITS-1:0] nb_down,
   input  logic [VALUE_BITS-1:0] nb_left,
   input  logic [VALUE_BITS-1:0] nb_right,
   output logic [VALUE_BITS-1:0] result
);

   localparam int LAPW  = VALUE_BITS + 3;
   localparam int PRODW = LAPW + ALPHA_BITS + 1;
   localparam int SUMW  = VALUE_BITS + FRAC_BITS + 1;
   localparam int TW    = ((PRODW > SUMW) ? PRODW : SUMW) + 1;

   logic [LAPW-1:0]         sum4;
   logic signed [LAPW-1:0]  lap;
   logic signed [PRODW-1:0] prod_in;
   logic signed [PRODW-1:0] prod_ff;
   logic [VALUE_BITS-1:0]   center_ff;
   logic [TW-1:0]           t;

   always_comb begin
      sum4    = LAPW'(nb_up) + LAPW'(nb_down) + LAPW'(nb_left) + LAPW'(nb_right);
      lap     = $signed(sum4 - (LAPW'(center) << 2));
      prod_in = $signed({1'b0, alpha}) * lap;
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      center_ff <= center;
   end

   always_comb begin
      t = (TW'(center_ff) << FRAC_BITS) + TW'(prod_ff) + (TW'(1) << (FRAC_BITS - 1));
      if (t[TW-1]) begin
         result = '0;
      end else if (t[TW-2:FRAC_BITS+VALUE_BITS] != '0) begin
         result = '1;
      end else begin
         result = t[FRAC_BITS+VALUE_BITS-1:FRAC_BITS];
      end
   end

endmodule
